FILE: rtl/core/hcs_pkg.sv
// Package for the heading circular smoother: widths, constants, CORDIC arctangent table.
// No dependencies.
package hcs_pkg;
  localparam int AngW = 17;
  localparam int OutW = 16;
  localparam int WgtW = 16;
  localparam int VecW = 18;
  localparam int Steps = 20;
  localparam int StepW = 5;
  // Internal angle: degrees with 16 fraction bits.
  localparam int ZW = 28;
  localparam int CW = 34;
  localparam logic signed [ZW-1:0] Deg90  = 28'sd5898240;
  localparam logic signed [ZW-1:0] Deg180 = 28'sd11796480;
  localparam logic signed [ZW-1:0] Deg360 = 28'sd23592960;
  localparam logic signed [AngW+1:0] Turn = 19'sd46080;
  localparam logic signed [CW-1:0] KStart = 34'sd39797;
  localparam logic signed [CW-1:0] Lim29 = 34'sd536870912;
  localparam logic [2:0] REG_WEIGHT = 3'd0;
  localparam logic [2:0] REG_OFFSET = 3'd1;
  localparam int CfgIdxW = 3;

  typedef struct packed {
    logic load;     // latch input, start reduction
    logic rot_init;
    logic rot_step;
    logic rot_done;
    logic blend;
    logic vec_norm;
    logic vec_init;
    logic vec_step;
    logic finish;
  } hcs_cmd_t;

  typedef struct packed {
    logic norm_done;
  } hcs_sts_t;

  function automatic logic signed [ZW-1:0] atan_deg(input logic [StepW-1:0] i);
    case (i)
      5'd0: return 28'sd2949120;   5'd1: return 28'sd1740967;
      5'd2: return 28'sd919879;    5'd3: return 28'sd466945;
      5'd4: return 28'sd234379;    5'd5: return 28'sd117304;
      5'd6: return 28'sd58666;     5'd7: return 28'sd29335;
      5'd8: return 28'sd14668;     5'd9: return 28'sd7334;
      5'd10: return 28'sd3667;     5'd11: return 28'sd1833;
      5'd12: return 28'sd917;      5'd13: return 28'sd458;
      5'd14: return 28'sd229;      5'd15: return 28'sd115;
      5'd16: return 28'sd57;       5'd17: return 28'sd29;
      5'd18: return 28'sd14;       5'd19: return 28'sd7;
      default: return 28'sd0;
    endcase
  endfunction
endpackage

FILE: rtl/core/hcs_stream_if.sv
// Valid/ready channel interface used for input, result and configuration beats.
// Depends on nothing.
interface hcs_stream_if #(parameter int W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/hcs_ctrl.sv
// Sequencer for the smoother: steps the shared CORDIC datapath through one item.
// Depends on hcs_pkg.
module hcs_ctrl import hcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  input  hcs_sts_t sts,
  output logic busy,
  output logic out_valid,
  output hcs_cmd_t cmd,
  output logic [StepW-1:0] step
);
  localparam logic [2:0] S_IDLE = 3'd0, S_ROT = 3'd1, S_BLEND = 3'd2, S_NORM = 3'd3,
                         S_VEC = 3'd4, S_FIN = 3'd5, S_OUT = 3'd6, S_RINIT = 3'd7;
  logic [2:0] state_r, state_nxt;
  logic [StepW-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    cmd = '0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_nxt = S_RINIT;
      end
      S_RINIT: begin
        cmd.rot_init = 1'b1;
        step_nxt = '0;
        state_nxt = S_ROT;
      end
      S_ROT: begin
        cmd.rot_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(Steps - 1)) state_nxt = S_BLEND;
      end
      S_BLEND: begin
        cmd.rot_done = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (step_r == '0) begin
          cmd.blend = 1'b1;
          step_nxt = 5'd1;
        end else if (sts.norm_done) begin
          cmd.vec_init = 1'b1;
          step_nxt = '0;
          state_nxt = S_VEC;
        end else begin
          cmd.vec_norm = 1'b1;
        end
      end
      S_VEC: begin
        cmd.vec_step = 1'b1;
        step_nxt = step_r + 1'b1;
        if (step_r == StepW'(Steps - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // Enter blend with step cleared.
    if (state_r == S_BLEND) step_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r <= '0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign step = step_r;
endmodule

FILE: rtl/core/hcs_dp.sv
// Datapath for the smoother: shared CORDIC x/y/z registers, averages and output rounding.
// Depends on hcs_pkg.
module hcs_dp import hcs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  hcs_cmd_t cmd,
  input  logic [StepW-1:0] step,
  input  logic signed [AngW-1:0] heading_in,
  input  logic [WgtW-1:0] weight,
  input  logic signed [AngW-1:0] offset,
  output hcs_sts_t sts,
  output logic [OutW-1:0] heading_out
);
  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r, base_r;
  logic neg_r, primed_r;
  logic signed [VecW-1:0] avg_c_r, avg_s_r;
  logic [OutW-1:0] out_r;
  logic signed [AngW+1:0] a_r;

  logic signed [AngW+1:0] hin, a_mod;
  logic signed [ZW-1:0] zin, zf;
  logic rneg;
  logic signed [CW-1:0] xs, ys, xn, yn, nx, ny, ax, ay;
  logic rot_dir, vec_dir;
  logic signed [VecW-1:0] cc, ss;
  logic signed [VecW+1:0] dc, ds;
  logic signed [VecW+WgtW+2:0] pc, ps;
  logic signed [ZW+1:0] sum;
  logic signed [ZW-8:0] rnd;
  logic signed [ZW-8:0] rm;

  function automatic logic signed [VecW-1:0] clampu(input logic signed [CW-1:0] v);
    if (v > 34'sd65536) return 18'sd65536;
    if (v < -34'sd65536) return -18'sd65536;
    return v[VecW-1:0];
  endfunction

  always_comb begin
    hin = {{2{heading_in[AngW-1]}}, heading_in};
    // Input range is within two turns, so at most one correction each way.
    a_mod = hin;
    if (hin >= Turn) a_mod = hin - Turn;
    else if (hin <= -Turn) a_mod = hin + Turn;
    if (a_mod < 0) a_mod = a_mod + Turn;
    zin = ZW'(a_r) <<< 9;
    if (zin >= Deg180) zin = zin - Deg360;
    // Fold the angle into the right half plane; the vector is negated afterwards.
    zf = zin;
    rneg = 1'b0;
    if (zin > Deg90) begin
      zf = zin - Deg180;
      rneg = 1'b1;
    end else if (zin < -Deg90) begin
      zf = zin + Deg180;
      rneg = 1'b1;
    end
    xs = x_r >>> step;
    ys = y_r >>> step;
    rot_dir = (z_r >= 0);
    vec_dir = (y_r > 0);
    ax = x_r[CW-1] ? -x_r : x_r;
    ay = y_r[CW-1] ? -y_r : y_r;
    sts.norm_done = (ax >= Lim29) || (ay >= Lim29) || (x_r == 0 && y_r == 0);
    cc = clampu(neg_r ? -x_r : x_r);
    ss = clampu(neg_r ? -y_r : y_r);
    dc = {{2{cc[VecW-1]}}, cc} - {{2{avg_c_r[VecW-1]}}, avg_c_r};
    ds = {{2{ss[VecW-1]}}, ss} - {{2{avg_s_r[VecW-1]}}, avg_s_r};
    pc = dc * $signed({1'b0, weight}) + 35'sd32768;
    ps = ds * $signed({1'b0, weight}) + 35'sd32768;
    sum = (ZW+2)'(z_r) + ((ZW+2)'(offset) <<< 9);
    rnd = (ZW-7)'((sum + 30'sd256) >>> 9);
    rm = rnd;
    // Sum spans under three turns each way; reduce into [0, turn).
    if (rm >= 21'sd46080) rm = rm - 21'sd46080;
    if (rm >= 21'sd46080) rm = rm - 21'sd46080;
    if (rm < 0) rm = rm + 21'sd46080;
    if (rm < 0) rm = rm + 21'sd46080;
    if (rm < 0) rm = rm + 21'sd46080;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      avg_c_r <= '0;
      avg_s_r <= '0;
    end else if (cmd.rot_done) begin
      if (!primed_r) begin
        avg_c_r <= cc;
        avg_s_r <= ss;
        primed_r <= 1'b1;
      end
    end else if (cmd.blend && primed_r && step == '0 && base_r[0]) begin
      avg_c_r <= avg_c_r + VecW'(pc >>> 16);
      avg_s_r <= avg_s_r + VecW'(ps >>> 16);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) a_r <= a_mod;
    if (cmd.rot_init) begin
      neg_r <= rneg;
      z_r <= zf;
      x_r <= KStart;
      y_r <= '0;
    end
    if (cmd.rot_step) begin
      if (rot_dir) begin
        x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_deg(step);
      end else begin
        x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_deg(step);
      end
    end
    // base_r[0] marks whether the average was already primed before this item.
    if (cmd.rot_done) base_r <= {27'd0, primed_r};
    if (cmd.blend) begin
      if (primed_r && base_r[0]) begin
        x_r <= CW'(avg_c_r + VecW'(pc >>> 16));
        y_r <= CW'(avg_s_r + VecW'(ps >>> 16));
      end else begin
        x_r <= CW'(avg_c_r);
        y_r <= CW'(avg_s_r);
      end
    end
    if (cmd.vec_norm) begin
      x_r <= x_r <<< 1;
      y_r <= y_r <<< 1;
    end
    if (cmd.vec_init) begin
      base_r <= '0;
      if (x_r[CW-1]) begin
        x_r <= -x_r; y_r <= -y_r; z_r <= Deg180;
      end else begin
        z_r <= '0;
      end
    end
    if (cmd.vec_step) begin
      // A zero average keeps its angle at zero through every step.
      if (x_r == 0 && y_r == 0) begin
        z_r <= z_r;
      end else if (vec_dir) begin
        x_r <= x_r + ys; y_r <= y_r - xs; z_r <= z_r + atan_deg(step);
      end else begin
        x_r <= x_r - ys; y_r <= y_r + xs; z_r <= z_r - atan_deg(step);
      end
    end
    if (cmd.finish) out_r <= OutW'(rm);
  end

  assign heading_out = out_r;
endmodule

FILE: rtl/core/heading_circular_smoother.sv
// Top level of the heading circular smoother: channel handshakes, registers, ctrl + datapath.
// Depends on hcs_pkg, hcs_stream_if, hcs_ctrl and hcs_dp.
//
// Each input beat is a compass heading in degrees with 7 fraction bits. It is turned into
// a unit vector by 20 CORDIC rotations, blended into an exponential moving average of x and
// y (the first beat after reset loads the average), and the average's angle is found by 20
// CORDIC vectoring steps, offset and wrapped into 0 to below 360 degrees. One shared CORDIC
// unit does all of this, in order: setting up, 20 rotations, latching, the blend, the
// normalising doublings (none for a zero average, about 13 for a full-length one, up to 29
// for a tiny one), starting vectoring, 20 vectoring steps and rounding. The normalisation
// is what makes the time to a result vary. One item is in work at a time; the next input
// is accepted at the earliest in the cycle after the result beat is taken. Configuration
// beats are always accepted: index 0 sets the weight of a new sample (Q0.16), index 1 the
// heading offset; other indexes are ignored. Write them only while no item is in flight,
// as the weight is used at the blend and the offset at the final rounding.
module heading_circular_smoother import hcs_pkg::*; (
  input logic clk,
  input logic rst_n,
  hcs_stream_if.sink in_ch,
  hcs_stream_if.source out_ch,
  hcs_stream_if.sink cfg_ch
);
  logic [WgtW-1:0] weight_r;
  logic signed [AngW-1:0] offset_r;
  logic busy, in_fire, out_fire;
  hcs_cmd_t cmd;
  hcs_sts_t sts;
  logic [StepW-1:0] step;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [WgtW+AngW-1:0] cfg_data;

  assign in_ch.ready = !busy;
  assign cfg_ch.ready = 1'b1;
  assign in_fire = in_ch.valid && !busy;
  assign out_fire = out_ch.valid && out_ch.ready;
  // Config beat: index in the top bits, data in the low 17.
  assign cfg_idx = cfg_ch.data[AngW+CfgIdxW-1:AngW];
  assign cfg_data = {{WgtW{1'b0}}, cfg_ch.data[AngW-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weight_r <= 16'd655;
      offset_r <= -17'sd11520;
    end else if (cfg_ch.valid) begin
      case (cfg_idx)
        REG_WEIGHT: weight_r <= cfg_data[WgtW-1:0];
        REG_OFFSET: offset_r <= cfg_data[AngW-1:0];
        default: ;
      endcase
    end
  end

  hcs_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .sts, .busy,
    .out_valid(out_ch.valid), .cmd, .step
  );

  hcs_dp u_dp (
    .clk, .rst_n, .cmd, .step, .heading_in(in_ch.data[AngW-1:0]),
    .weight(weight_r), .offset(offset_r), .sts, .heading_out(out_ch.data[OutW-1:0])
  );
endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the heading circular smoother.
// Depends on hcs_pkg, hcs_stream_if and the heading_circular_smoother RTL.
// A predictor inside the bench mirrors the CORDIC averaging and is checked against every result beat.
module testbench;
  import hcs_pkg::*;

  localparam int CfgW = CfgIdxW + AngW;
  localparam longint TurnA = 46080;       // full turn, 7 fraction bits
  localparam longint UpScale = 512;       // 7 to 16 fraction bits

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hcs_stream_if #(.W(AngW)) in_ch ();
  hcs_stream_if #(.W(OutW)) out_ch ();
  hcs_stream_if #(.W(CfgW)) cfg_ch ();

  heading_circular_smoother dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // The clock runs with a period of 10 time units.
  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------------
  // Predictor state: our own copy of the averages and the two registers.
  // ---------------------------------------------------------------------------------
  longint avg_x, avg_y;
  bit primed_avg;
  logic [WgtW-1:0] weight_reg;
  logic signed [AngW-1:0] offset_reg;

  logic [OutW-1:0] heading_q[$];   // headings still awaited on the result channel
  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;                // when set, neither side idles

  const longint atan_tab[Steps] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // Rotation mode: angle z (degrees, 16 fraction bits, within one turn) to a unit vector.
  function automatic void angle_to_vector(input longint z, output longint c,
                                          output longint s);
    longint x, y, t, lim;
    bit flip;
    flip = 1'b0;
    lim = 65536;
    if (z >= 180 * 65536) z -= 360 * 65536;
    if (z > 90 * 65536) begin
      z -= 180 * 65536;
      flip = 1'b1;
    end else if (z < -90 * 65536) begin
      z += 180 * 65536;
      flip = 1'b1;
    end
    x = (longint'(652032874) + 8192) >>> 14;
    y = 0;
    for (int i = 0; i < Steps; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tab[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = (x > lim) ? lim : (x < -lim) ? -lim : x;
    s = (y > lim) ? lim : (y < -lim) ? -lim : y;
  endfunction

  // Vectoring mode: angle of (x, y) in degrees with 16 fraction bits; zero for a zero vector.
  function automatic longint vector_to_angle(input longint x, input longint y);
    longint base, z, t, ax, ay;
    base = 0;
    z = 0;
    if (x == 0 && y == 0) return 0;
    forever begin
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ax >= (longint'(1) << 29) || ay >= (longint'(1) << 29)) break;
      x *= 2;
      y *= 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      base = 180 * 65536;
    end
    for (int i = 0; i < Steps; i++) begin
      if (y > 0) begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; z += atan_tab[i];
      end else begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; z -= atan_tab[i];
      end
    end
    return base + z;
  endfunction

  // Blends one raw heading into the average and returns the smoothed heading.
  function automatic logic [OutW-1:0] smoothed_heading(input logic signed [AngW-1:0] h);
    longint a, cx, sy, sum, r;
    a = longint'(h) % TurnA;
    if (a < 0) a += TurnA;
    angle_to_vector(a * UpScale, cx, sy);
    if (!primed_avg) begin
      avg_x = cx;
      avg_y = sy;
      primed_avg = 1'b1;
    end else begin
      avg_x += (longint'(weight_reg) * (cx - avg_x) + 32768) >>> 16;
      avg_y += (longint'(weight_reg) * (sy - avg_y) + 32768) >>> 16;
    end
    sum = vector_to_angle(avg_x, avg_y) + longint'(offset_reg) * UpScale;
    r = (sum + UpScale / 2) >>> 9;
    r %= TurnA;
    if (r < 0) r += TurnA;
    return r[OutW-1:0];
  endfunction

  // ---------------------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------------------
  task automatic report(input string what);
    errors++;
    $display("tb: mismatch at %0t: %s", $realtime, what);
  endtask

  // Every result beat is compared with the oldest awaited heading.
  always @(posedge clk) begin
    logic [OutW-1:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (heading_q.size() == 0) begin
        report($sformatf("unexpected result beat, heading_out=%0d", out_ch.data));
      end else begin
        want = heading_q.pop_front();
        if (out_ch.data !== want)
          report($sformatf("heading_out=%0d, expected %0d", out_ch.data, want));
      end
    end
  end

  // The result side stalls in random bursts, except in the quiet part.
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------------

  // Sends one heading beat; valid stays high afterwards so that back-to-back beats
  // need only one assignment per edge.
  task automatic send_heading(input logic signed [AngW-1:0] h);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= h;
    do @(posedge clk); while (!in_ch.ready);
    heading_q.push_back(smoothed_heading(h));
    items_sent++;
  endtask

  // Drops valid and waits for every awaited result, plus a short margin.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (heading_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Register write, only while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [AngW-1:0] val);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= {idx, val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_WEIGHT) weight_reg = val[WgtW-1:0];
    else if (idx == REG_OFFSET) offset_reg = val;
    cfg_writes++;
  endtask

  // A heading near a centre, with noise, kept in the legal field range.
  function automatic logic signed [AngW-1:0] near(input int centre, input int spread);
    int v;
    v = centre + $urandom_range(0, 2 * spread) - spread;
    if (v > 46080) v -= 46080;
    if (v < -46080) v += 46080;
    return AngW'(v);
  endfunction

  // ---------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------

  // Priming with 0 degrees and then 180 at half weight cancels the average exactly,
  // so the zero-vector case gives the wrapped offset.
  task automatic test_zero_average;
    write_reg(REG_WEIGHT, 17'd32768);
    send_heading(17'sd0);
    send_heading(17'sd23040);
    send_heading(-17'sd23040);
    drain();
  endtask

  // Field extremes and angles outside plus or minus 360 degrees.
  task automatic test_heading_extremes;
    write_reg(REG_WEIGHT, 17'd65535);
    send_heading(-17'sd46080);
    send_heading(17'sd46080);
    send_heading(17'sd46079);
    send_heading(-17'sd65536);
    send_heading(17'sd65535);
    send_heading(17'sd11520);
    send_heading(-17'sd11520);
    send_heading(17'sd1);
    send_heading(-17'sd1);
    send_heading(17'sd34560);
  endtask

  // Weight and offset extremes, weight zero, and writes to unused indexes.
  task automatic test_register_extremes;
    write_reg(REG_WEIGHT, 17'd0);
    send_heading(17'sd5760);
    send_heading(17'sd40000);
    write_reg(REG_WEIGHT, 17'd1);
    write_reg(REG_OFFSET, 17'h0B400);     // +360 degrees
    send_heading(17'sd20000);
    write_reg(REG_OFFSET, -17'sd46080);
    send_heading(17'sd100);
    write_reg(REG_OFFSET, 17'sd65535);    // beyond the documented range, still wraps
    send_heading(17'sd30000);
    write_reg(REG_OFFSET, -17'sd65536);
    send_heading(-17'sd30000);
    write_reg(3'd2, 17'h1FFFF);
    write_reg(3'd7, 17'h00000);
    send_heading(17'sd12345);
    write_reg(REG_OFFSET, 17'sd0);
    send_heading(17'sd23040);
    drain();
  endtask

  // Mostly a slowly wandering heading with noise, sometimes across north, some raw noise.
  task automatic test_random_tracking(input int count);
    int centre;
    centre = $urandom_range(0, 46079);
    for (int n = 0; n < count; n++) begin
      centre += $urandom_range(0, 800) - 400;
      if (centre < 0) centre += 46080;
      if (centre >= 46080) centre -= 46080;
      if ($urandom_range(0, 9) == 0)
        send_heading(AngW'($urandom));
      else if ($urandom_range(0, 29) == 0)
        send_heading(near(centre + 23040, 3000));
      else
        send_heading(near(centre, $urandom_range(0, 3) == 0 ? 6000 : 600));
      // Hold off once per phase until the block has caught up completely.
      if (n == count / 2) drain();
    end
  endtask

  task automatic test_random_settings;
    logic [AngW-1:0] w_set[6] = '{17'd655, 17'd65535, 17'd1, 17'd32768, 17'd6000, 17'd200};
    logic [AngW-1:0] o_set[6] = '{-17'sd11520, 17'sd11520, 17'sd46080, -17'sd46080,
                                  17'sd0, 17'sd777};
    for (int p = 0; p < 6; p++) begin
      write_reg(REG_WEIGHT, w_set[p]);
      write_reg(REG_OFFSET, o_set[p]);
      test_random_tracking(250);
    end
    write_reg(REG_WEIGHT, AngW'($urandom_range(1, 65535)));
    write_reg(REG_OFFSET, AngW'($urandom));
    test_random_tracking(200);
    // Last stretch with both sides running flat out.
    quiet = 1'b1;
    write_reg(REG_WEIGHT, 17'd2000);
    test_random_tracking(150);
    drain();
  endtask

  // ---------------------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------------------
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    avg_x = 0;
    avg_y = 0;
    primed_avg = 1'b0;
    weight_reg = 16'd655;
    offset_reg = -17'sd11520;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_average();
    test_heading_extremes();
    test_register_extremes();
    test_random_settings();

    drain();
    repeat (100) @(posedge clk);
    $display("tb: %0d headings sent, %0d results checked, %0d register writes",
             items_sent, results_seen, cfg_writes);
    $display("tb: covered priming, cancelled averages, wrap across north and register extremes");
    if (errors == 0 && heading_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end
endmodule

FILE: heading_circular_smoother.f
rtl/core/hcs_pkg.sv
rtl/core/hcs_stream_if.sv
rtl/core/hcs_ctrl.sv
rtl/core/hcs_dp.sv
rtl/core/heading_circular_smoother.sv
tb/testbench.sv
